/* sv/lpmd_pkg.sv */
// Types and constants shared by the message deframer.
`default_nettype none
package lpmd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CONSUMED_W = 16;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = 8'd1;

  localparam logic [31:0] MAGIC_RESET = 32'h5844_5A40;
  localparam logic [15:0] TYPE_RESET  = 16'h0000;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    ST_PAYLOAD,
    ST_EMPTY,
    ST_BAD_HEADER,
    ST_BAD_TYPE,
    ST_INCOMPLETE
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [7:0]              data;
    logic                    last;
    logic                    trunc;
    logic [CONSUMED_W-1:0]   offs;
  } res_t;

endpackage
`default_nettype wire

/* sv/lpmd_if.sv */
// Valid/ready channel interfaces for input bytes, results and configuration writes.
`default_nettype none
interface lpmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface lpmd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic        message_last;
  logic        truncated;
  logic [15:0] consumed_bytes;

  modport source (output valid, output payload_byte, output status, output message_last,
                  output truncated, output consumed_bytes, input ready);
  modport sink   (input valid, input payload_byte, input status, input message_last,
                  input truncated, input consumed_bytes, output ready);
endinterface

interface lpmd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpmd_pkg::CFG_IDX_W-1:0]  index;
  logic [lpmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/length_prefixed_message_deframer.sv */
// Top level of the length-prefixed message deframer.
// Takes one received byte per beat and, when the downstream side keeps up, one beat every
// cycle; the result for a byte passes through the result queue and the output register to out_ch.
// in_ch.ready falls only when the four-entry result queue between parser
// and output register is full. Each message is a 4-byte magic header, a 16-bit
// little-endian type and a 32-bit little-endian length followed by the payload; a byte with
// buffer_end set returns the parser to the header phase. Configuration writes are always
// accepted, take effect on the next cycle and must only be issued while no accepted byte is
// still in flight.
`default_nettype none
module length_prefixed_message_deframer #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpmd_in_if.sink    in_ch,
  lpmd_cfg_if.sink   cfg_ch,
  lpmd_out_if.source out_ch
);
  import lpmd_pkg::*;

  res_t tok;
  res_t q_head;
  logic tok_vld;
  logic q_full;
  logic q_empty;
  logic q_pop;

  lpmd_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_full  (q_full),
    .tok_vld (tok_vld),
    .tok     (tok)
  );

  lpmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tok_vld),
    .push_data (tok),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  lpmd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

/* sv/lpmd_front.sv */
// Front end: configuration registers and the byte parser that classifies each beat.
`default_nettype none
module lpmd_front #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  lpmd_in_if.sink             in_ch,
  lpmd_cfg_if.sink            cfg_ch,
  input  wire logic           q_full,
  output logic                tok_vld,
  output lpmd_pkg::res_t      tok
);
  import lpmd_pkg::*;

  logic [31:0]            magic_r;
  logic [15:0]            exp_type_r;
  phase_t                 phase_r, phase_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [23:0]            acc_r, acc_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] start_cur;
  logic [CONSUMED_W-1:0]  start_sat;
  logic [31:0]            len_full;
  logic                   in_fire;
  logic                   no_incomplete;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= MAGIC_RESET;
      exp_type_r <= TYPE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MAGIC_WORD:    magic_r    <= cfg_ch.data;
        CFG_EXPECTED_TYPE: exp_type_r <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  assign start_cur = (phase_r == PH_HEADER && idx_r == 2'd0) ? off_r : start_r;
  assign len_full  = {in_ch.data_byte, acc_r};

  generate
    if (OFFSET_BITS > CONSUMED_W) begin : g_sat
      assign start_sat = (|start_cur[OFFSET_BITS-1:CONSUMED_W]) ? '1
                                                                : start_cur[CONSUMED_W-1:0];
    end else if (OFFSET_BITS == CONSUMED_W) begin : g_same
      assign start_sat = start_cur;
    end else begin : g_ext
      assign start_sat = {{(CONSUMED_W-OFFSET_BITS){1'b0}}, start_cur};
    end
  endgenerate

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    start_nxt     = start_cur;
    off_nxt       = off_r;
    no_incomplete = 1'b0;
    tok_vld       = 1'b0;
    tok.status    = ST_PAYLOAD;
    tok.data      = in_ch.data_byte;
    tok.last      = 1'b0;
    tok.trunc     = 1'b0;
    tok.offs      = start_sat;

    unique case (phase_r)
      PH_HEADER: begin
        if (in_ch.data_byte != magic_r[8*idx_r +: 8]) begin
          tok_vld       = 1'b1;
          tok.status    = ST_BAD_HEADER;
          no_incomplete = 1'b1;
          phase_nxt     = PH_DROP;
        end else if (idx_r == 2'd3) begin
          idx_nxt   = 2'd0;
          phase_nxt = PH_TYPE;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      PH_TYPE: begin
        if (idx_r == 2'd0) begin
          acc_nxt[7:0] = in_ch.data_byte;
          idx_nxt      = 2'd1;
        end else begin
          if ({in_ch.data_byte, acc_r[7:0]} != exp_type_r) begin
            tok_vld       = 1'b1;
            tok.status    = ST_BAD_TYPE;
            no_incomplete = 1'b1;
            phase_nxt     = PH_DROP;
          end else begin
            phase_nxt = PH_LENGTH;
          end
          idx_nxt = 2'd0;
        end
      end
      PH_LENGTH: begin
        if (idx_r == 2'd3) begin
          idx_nxt       = 2'd0;
          no_incomplete = 1'b1;
          if (len_full == 32'd0) begin
            tok_vld    = 1'b1;
            tok.status = ST_EMPTY;
            phase_nxt  = PH_HEADER;
          end else begin
            rem_nxt   = len_full;
            phase_nxt = PH_PAYLOAD;
            if (in_ch.buffer_end) begin
              tok_vld    = 1'b1;
              tok.status = ST_EMPTY;
              tok.trunc  = 1'b1;
            end
          end
        end else begin
          acc_nxt[8*idx_r +: 8] = in_ch.data_byte;
          idx_nxt               = idx_r + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        no_incomplete = 1'b1;
        rem_nxt       = rem_r - 32'd1;
        tok_vld       = 1'b1;
        if (rem_r == 32'd1) begin
          tok.last  = 1'b1;
          phase_nxt = PH_HEADER;
          idx_nxt   = 2'd0;
        end else begin
          tok.trunc = in_ch.buffer_end;
        end
      end
      PH_DROP: begin
        no_incomplete = 1'b1;
      end
      default: begin
        no_incomplete = 1'b1;
        phase_nxt     = PH_HEADER;
        idx_nxt       = 2'd0;
      end
    endcase

    if (in_ch.buffer_end) begin
      if (!no_incomplete && !tok_vld &&
          (phase_nxt == PH_HEADER || phase_nxt == PH_TYPE || phase_nxt == PH_LENGTH) &&
          (phase_nxt != PH_HEADER || idx_nxt != 2'd0)) begin
        tok_vld    = 1'b1;
        tok.status = ST_INCOMPLETE;
      end
      phase_nxt = PH_HEADER;
      idx_nxt   = 2'd0;
      acc_nxt   = '0;
      rem_nxt   = '0;
      off_nxt   = '0;
      start_nxt = '0;
    end else if (off_r != '1) begin
      off_nxt = off_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    end

    if (!in_fire) begin
      tok_vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      off_r   <= '0;
      start_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
    end
  end

  a_push_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld |-> in_fire)
    else $error("result pushed without an input beat");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.buffer_end |=> phase_r == PH_HEADER && off_r == '0 && idx_r == 2'd0)
    else $error("parser not reset after buffer end");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != 32'd0)
    else $error("payload phase with nothing remaining");

endmodule
`default_nettype wire

/* sv/lpmd_queue.sv */
// Short result queue between the parser and the output stage.
`default_nettype none
module lpmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  lpmd_pkg::res_t      push_data,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output lpmd_pkg::res_t      head
);
  import lpmd_pkg::*;

  res_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_pop;

  assign full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty  = (cnt_r == '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < Q_CNT_W'(Q_DEPTH))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

/* sv/lpmd_back.sv */
// Back end: output register that formats queued results onto the result channel.
`default_nettype none
module lpmd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  lpmd_pkg::res_t      q_head,
  output logic                q_pop,
  lpmd_out_if.source          out_ch
);
  import lpmd_pkg::*;

  logic                  vld_r;
  logic [7:0]            byte_r, byte_nxt;
  logic [2:0]            status_r;
  logic                  last_r;
  logic                  trunc_r;
  logic [CONSUMED_W-1:0] offs_r, offs_nxt;

  assign q_pop = !q_empty && (!vld_r || out_ch.ready);

  always_comb begin
    byte_nxt = '0;
    offs_nxt = '0;
    unique case (q_head.status) inside
      ST_PAYLOAD: byte_nxt = q_head.data;
      ST_BAD_HEADER, ST_BAD_TYPE, ST_INCOMPLETE: offs_nxt = q_head.offs;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r   <= byte_nxt;
      status_r <= q_head.status;
      last_r   <= q_head.last;
      trunc_r  <= q_head.trunc;
      offs_r   <= offs_nxt;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.payload_byte   = byte_r;
  assign out_ch.status         = status_r;
  assign out_ch.message_last   = last_r;
  assign out_ch.truncated      = trunc_r;
  assign out_ch.consumed_bytes = offs_r;

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the length-prefixed message deframer: directed and random buffers.
module tb;
  import lpmd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } cfg_wr_t;

  logic clk;
  logic rst_n;

  lpmd_in_if  in_ch();
  lpmd_out_if out_ch();
  lpmd_cfg_if cfg_ch();

  length_prefixed_message_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // deframer model state
  logic [31:0] mdl_magic;
  logic [15:0] mdl_type;
  phase_t      mdl_phase;
  logic [1:0]  mdl_idx;
  logic [31:0] mdl_acc;
  logic [31:0] mdl_remain;
  logic [15:0] mdl_offset;
  logic [15:0] mdl_msg_start;

  res_t    pending_results[$];
  beat_t   rx_beats[$];
  cfg_wr_t cfg_writes[$];
  logic [7:0] rx_buf[$];

  int beats_queued = 0;
  int beats_taken = 0;
  int cfg_queued = 0;
  int cfg_taken = 0;
  int n_errors = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  bit steady = 1'b0;
  bit pressure_go = 1'b0;
  logic rx_hold = 1'b0;

  logic [31:0] cur_magic;
  logic [15:0] cur_type;

  function automatic res_t mk_result(status_t st, logic [7:0] d, logic l, logic t,
                                     logic [15:0] o);
    res_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    r.trunc  = t;
    r.offs   = o;
    return r;
  endfunction

  task automatic clear_parser();
    mdl_phase     = PH_HEADER;
    mdl_idx       = '0;
    mdl_acc       = '0;
    mdl_remain    = '0;
    mdl_offset    = '0;
    mdl_msg_start = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic eob);
    res_t r;
    bit   got;
    bit   inc_ok;
    got = 1'b0;
    inc_ok = 1'b1;
    r = '0;
    case (mdl_phase)
      PH_HEADER: begin
        if (mdl_idx == 0) mdl_msg_start = mdl_offset;
        if (b != mdl_magic[8*mdl_idx +: 8]) begin
          r = mk_result(ST_BAD_HEADER, 8'h00, 1'b0, 1'b0, mdl_msg_start);
          got = 1'b1;
          inc_ok = 1'b0;
          mdl_phase = PH_DROP;
        end else if (mdl_idx == 2'd3) begin
          mdl_idx = '0;
          mdl_acc = '0;
          mdl_phase = PH_TYPE;
        end else begin
          mdl_idx++;
        end
      end
      PH_TYPE: begin
        mdl_acc |= 32'(b) << (8 * mdl_idx[0]);
        if (mdl_idx != 0) begin
          if (mdl_acc[15:0] != mdl_type) begin
            r = mk_result(ST_BAD_TYPE, 8'h00, 1'b0, 1'b0, mdl_msg_start);
            got = 1'b1;
            inc_ok = 1'b0;
            mdl_phase = PH_DROP;
          end else begin
            mdl_phase = PH_LENGTH;
          end
          mdl_idx = '0;
          mdl_acc = '0;
        end else begin
          mdl_idx++;
        end
      end
      PH_LENGTH: begin
        mdl_acc |= 32'(b) << (8 * mdl_idx);
        if (mdl_idx == 2'd3) begin
          mdl_idx = '0;
          inc_ok = 1'b0;
          if (mdl_acc == 0) begin
            r = mk_result(ST_EMPTY, 8'h00, 1'b0, 1'b0, 16'h0000);
            got = 1'b1;
            mdl_phase = PH_HEADER;
          end else begin
            mdl_remain = mdl_acc;
            mdl_phase = PH_PAYLOAD;
            if (eob) begin
              r = mk_result(ST_EMPTY, 8'h00, 1'b0, 1'b1, 16'h0000);
              got = 1'b1;
            end
          end
          mdl_acc = '0;
        end else begin
          mdl_idx++;
        end
      end
      PH_PAYLOAD: begin
        inc_ok = 1'b0;
        mdl_remain--;
        if (mdl_remain == 0) begin
          r = mk_result(ST_PAYLOAD, b, 1'b1, 1'b0, 16'h0000);
          mdl_phase = PH_HEADER;
          mdl_idx = '0;
        end else begin
          r = mk_result(ST_PAYLOAD, b, 1'b0, eob, 16'h0000);
        end
        got = 1'b1;
      end
      default: inc_ok = 1'b0;
    endcase
    if (eob) begin
      if (inc_ok && !got && ((mdl_phase == PH_HEADER && mdl_idx != 0) ||
          mdl_phase == PH_TYPE || mdl_phase == PH_LENGTH)) begin
        r = mk_result(ST_INCOMPLETE, 8'h00, 1'b0, 1'b0, mdl_msg_start);
        got = 1'b1;
      end
      clear_parser();
    end else if (mdl_offset != 16'hFFFF) begin
      mdl_offset++;
    end
    if (got) pending_results = {pending_results, r};
  endtask

  // input driver
  beat_t nb;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        deframe_byte(in_ch.data_byte, in_ch.buffer_end);
        beats_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap != 0) begin
          in_ch.valid <= 1'b0;
          tx_gap--;
        end else if (!steady && $urandom_range(0, 11) == 0) begin
          in_ch.valid <= 1'b0;
          tx_gap = $urandom_range(0, 4);
        end else if (rx_beats.size() != 0) begin
          nb = rx_beats.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= nb.data;
          in_ch.buffer_end <= nb.eob;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  cfg_wr_t cw;
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MAGIC_WORD:    mdl_magic = cfg_ch.data;
          CFG_EXPECTED_TYPE: mdl_type = cfg_ch.data[15:0];
          default: ;
        endcase
        cfg_taken++;
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (cfg_writes.size() != 0) begin
          cw = cfg_writes.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= cw.idx;
          cfg_ch.data  <= cw.val;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string fld, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: %s expected %0h actual %0h", $time, fld, exp_v, act_v);
    n_errors++;
  endtask

  // result monitor
  res_t got_r;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result, status", 32'hx, 32'(out_ch.status));
        end else begin
          got_r = pending_results.pop_front();
          if (out_ch.status !== got_r.status)
            report("status", 32'(got_r.status), 32'(out_ch.status));
          if (out_ch.payload_byte !== got_r.data)
            report("payload_byte", 32'(got_r.data), 32'(out_ch.payload_byte));
          if (out_ch.message_last !== got_r.last)
            report("message_last", 32'(got_r.last), 32'(out_ch.message_last));
          if (out_ch.truncated !== got_r.trunc)
            report("truncated", 32'(got_r.trunc), 32'(out_ch.truncated));
          if (out_ch.consumed_bytes !== got_r.offs)
            report("consumed_bytes", 32'(got_r.offs), 32'(out_ch.consumed_bytes));
        end
      end
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_stall != 0) begin
        out_ch.ready <= 1'b0;
        rx_stall--;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        rx_stall = $urandom_range(0, 4);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the result queue fills and input backs up
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic add_frame(input logic [31:0] mg, input logic [15:0] ty, input logic [31:0] len,
                           input int body, input int bad_hdr, input bit bad_ty);
    logic [31:0] m;
    logic [15:0] t;
    m = mg;
    t = ty;
    if (bad_hdr >= 0) m[8*bad_hdr +: 8] = m[8*bad_hdr +: 8] ^ 8'($urandom_range(1, 255));
    if (bad_ty) t = t ^ 16'($urandom_range(1, 65535));
    for (int i = 0; i < 4; i++) rx_buf = {rx_buf, m[8*i +: 8]};
    for (int i = 0; i < 2; i++) rx_buf = {rx_buf, t[8*i +: 8]};
    for (int i = 0; i < 4; i++) rx_buf = {rx_buf, len[8*i +: 8]};
    for (int i = 0; i < body; i++) rx_buf = {rx_buf, 8'($urandom)};
  endtask

  // keep == 0 sends the whole buffer, else only its first keep bytes
  task automatic send_buffer(input int keep);
    beat_t bt;
    if (keep > 0)
      while (rx_buf.size() > keep) void'(rx_buf.pop_back());
    foreach (rx_buf[i]) begin
      bt.data = rx_buf[i];
      bt.eob = (i == rx_buf.size() - 1);
      rx_beats = {rx_beats, bt};
      beats_queued++;
    end
    rx_buf.delete();
  endtask

  task automatic random_buffer();
    int nmsg;
    int kind;
    int sel;
    int len;
    int keep;
    nmsg = $urandom_range(1, 3);
    for (int k = 0; k < nmsg; k++) begin
      kind = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      if (sel == 0) len = 0;
      else if (sel < 16) len = $urandom_range(1, 8);
      else if (sel < 19) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 300);
      if (kind < 70) begin
        add_frame(cur_magic, cur_type, len, len, -1, 1'b0);
      end else if (kind < 80) begin
        add_frame(cur_magic, cur_type, len, len, $urandom_range(0, 3), 1'b0);
      end else if (kind < 88) begin
        add_frame(cur_magic, cur_type, len, len, -1, 1'b1);
      end else if (kind < 94) begin
        // huge declared length, buffer ends inside the payload
        add_frame(cur_magic, cur_type, $urandom | 32'h100, $urandom_range(0, 6), -1, 1'b0);
        break;
      end else begin
        repeat ($urandom_range(1, 6)) rx_buf = {rx_buf, 8'($urandom)};
      end
    end
    keep = ($urandom_range(0, 5) == 0) ? $urandom_range(1, rx_buf.size()) : 0;
    send_buffer(keep);
  endtask

  task automatic drain();
    wait (beats_taken == beats_queued);
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] mg, input logic [15:0] ty);
    cfg_wr_t wr;
    wr.idx = CFG_MAGIC_WORD;
    wr.val = mg;
    cfg_writes = {cfg_writes, wr};
    wr.idx = CFG_EXPECTED_TYPE;
    wr.val = 32'(ty);
    cfg_writes = {cfg_writes, wr};
    cfg_queued += 2;
    wait (cfg_taken == cfg_queued);
    cur_magic = mg;
    cur_type = ty;
  endtask

  task automatic random_phase(input int n_beats);
    int start;
    start = beats_queued;
    while (beats_queued - start < n_beats) random_buffer();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.buffer_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    mdl_magic = MAGIC_RESET;
    mdl_type = TYPE_RESET;
    clear_parser();
    cur_magic = MAGIC_RESET;
    cur_type = TYPE_RESET;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset register values
    add_frame(cur_magic, cur_type, 2, 0, -1, 1'b0);
    rx_buf = {rx_buf, 8'h00};
    rx_buf = {rx_buf, 8'hFF};
    send_buffer(0);
    add_frame(cur_magic, cur_type, 0, 0, -1, 1'b0);
    add_frame(cur_magic, cur_type, 1, 1, -1, 1'b0);
    send_buffer(0);
    add_frame(cur_magic, cur_type, 3, 3, 2, 1'b0);
    send_buffer(0);
    add_frame(cur_magic, cur_type, 1, 1, -1, 1'b1);
    send_buffer(0);
    add_frame(cur_magic, cur_type, 5, 0, -1, 1'b0);
    send_buffer(0);
    add_frame(cur_magic, cur_type, 4, 4, -1, 1'b0);
    send_buffer(12);
    add_frame(cur_magic, cur_type, 0, 0, -1, 1'b0);
    send_buffer(2);
    add_frame(cur_magic, cur_type, 0, 0, -1, 1'b0);
    send_buffer(5);
    add_frame(cur_magic, cur_type, 0, 0, -1, 1'b0);
    send_buffer(8);
    add_frame(cur_magic, cur_type, 0, 0, -1, 1'b0);
    add_frame(cur_magic, cur_type, 0, 0, 0, 1'b0);
    send_buffer(0);
    drain();

    set_config(32'hFFFF_FFFF, 16'hFFFF);
    add_frame(cur_magic, cur_type, 2, 2, -1, 1'b0);
    send_buffer(0);
    add_frame(cur_magic, 16'hFFFE, 1, 1, -1, 1'b0);
    send_buffer(0);
    add_frame(cur_magic, cur_type, 1, 1, 3, 1'b0);
    send_buffer(0);
    drain();

    set_config(32'h0000_0000, 16'h0000);
    add_frame(cur_magic, cur_type, 1, 1, -1, 1'b0);
    send_buffer(0);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_config(32'hFFFF_FFFF, 16'hFFFF);
        2: set_config(32'h0000_0000, 16'h0000);
        default: set_config($urandom, 16'($urandom));
      endcase
      random_phase(210);
      if (p == 0) pressure_go = 1'b1;
      drain();
    end

    steady = 1'b1;
    set_config($urandom, 16'($urandom));
    random_phase(180);
    drain();

    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
